/* design/tle_pkg.sv */
// ----------------------------------------------------------------------------
// tle_pkg
// Types and key codes shared by the terminal line editor modules.
// ----------------------------------------------------------------------------
package tle_pkg;

    // key codes
    localparam logic [7:0] KEY_BS       = 8'd8;
    localparam logic [7:0] KEY_CR       = 8'd13;
    localparam logic [7:0] KEY_SO       = 8'd14;
    localparam logic [7:0] KEY_NAK      = 8'd21;
    localparam logic [7:0] KEY_ETB      = 8'd23;
    localparam logic [7:0] KEY_CAN      = 8'd24;
    localparam logic [7:0] KEY_SUB      = 8'd26;
    localparam logic [7:0] KEY_ESC      = 8'd27;
    localparam logic [7:0] CTRL_MAX     = 8'd31;
    localparam logic [7:0] KEY_SPACE    = 8'd32;
    localparam logic [7:0] KEY_DIGIT_0  = 8'd48;
    localparam logic [7:0] KEY_DIGIT_9  = 8'd57;
    localparam logic [7:0] KEY_SEMI     = 8'd59;
    localparam logic [7:0] KEY_LBRACKET = 8'd91;
    localparam logic [7:0] KEY_LOWER_A  = 8'd97;
    localparam logic [7:0] KEY_LOWER_Z  = 8'd122;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    // echo kinds
    localparam logic [1:0] ECHO_NONE    = 2'd0;
    localparam logic [1:0] ECHO_CHAR    = 2'd1;
    localparam logic [1:0] ECHO_CARET_Z = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W          = 2;
    localparam logic [1:0] CFG_MAX_LEN        = 2'd0;
    localparam logic [1:0] CFG_MIXED_CASE     = 2'd1;
    localparam logic [1:0] CFG_ENTER_REQUIRED = 2'd2;
    localparam logic [1:0] CFG_CTRL_Z_ALLOWED = 2'd3;

    localparam logic [7:0] MAX_LEN_RESET = 8'd80;

    typedef struct packed {
        logic [7:0] max_len;
        logic       mixed_case;
        logic       enter_required;
        logic       ctrl_z_allowed;
    } t_cfg;

    typedef struct packed {
        logic [1:0] echo_kind;
        logic [7:0] echo_char;
        logic [8:0] erase_cells;
        logic       store_valid;
        logic [7:0] store_pos;
        logic [7:0] store_char;
        logic       finished;
        logic       cancelled;
        logic [7:0] line_length;
    } t_result;

endpackage

/* design/tle_key_if.sv */
// ----------------------------------------------------------------------------
// tle_key_if
// Keystroke channel: one key byte per transaction.
// ----------------------------------------------------------------------------
interface tle_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_code;

    modport source (output valid, output key_code, input ready);
    modport sink   (input valid, input key_code, output ready);
endinterface

/* design/tle_result_if.sv */
// ----------------------------------------------------------------------------
// tle_result_if
// Result channel: one editing result per transaction.
// ----------------------------------------------------------------------------
interface tle_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] echo_kind;
    logic [7:0] echo_char;
    logic [8:0] erase_cells;
    logic       store_valid;
    logic [7:0] store_pos;
    logic [7:0] store_char;
    logic       finished;
    logic       cancelled;
    logic [7:0] line_length;

    modport source (
        output valid, input ready,
        output echo_kind, output echo_char, output erase_cells, output store_valid,
        output store_pos, output store_char, output finished, output cancelled,
        output line_length
    );
    modport sink (
        input valid, output ready,
        input echo_kind, input echo_char, input erase_cells, input store_valid,
        input store_pos, input store_char, input finished, input cancelled,
        input line_length
    );
endinterface

/* design/terminal_line_editor_core.sv */
// A key that erases nothing goes from the key transaction to a held result and
// then to the output register. Erasing keys add a read and a data step per line
// buffer read: one per erased position plus the read that finds the space
// ending a word erase. One key at a time; the next key is taken once its result
// is queued, so an unaccepted result holds off the next key.
// Reset: synchronous, active low; cursor, escape state and registers to defaults.
// ----------------------------------------------------------------------------
// terminal_line_editor_core
// Canonical line editor: configuration registers, sequencer and line buffer.
// ----------------------------------------------------------------------------
module terminal_line_editor_core
    import tle_pkg::*;
#(
    parameter int LINE_DEPTH = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tle_key_if.sink              i_key,
    tle_result_if.source         o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    localparam int AW = $clog2(LINE_DEPTH);

    t_cfg          r_cfg;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_len        <= MAX_LEN_RESET;
            r_cfg.mixed_case     <= 1'b0;
            r_cfg.enter_required <= 1'b1;
            r_cfg.ctrl_z_allowed <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_LEN:        r_cfg.max_len        <= i_cfg_data;
                CFG_MIXED_CASE:     r_cfg.mixed_case     <= i_cfg_data[0];
                CFG_ENTER_REQUIRED: r_cfg.enter_required <= i_cfg_data[0];
                CFG_CTRL_Z_ALLOWED: r_cfg.ctrl_z_allowed <= i_cfg_data[0];
            endcase
        end
    end

    tle_seq #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_key       (i_key),
        .o_result    (o_result),
        .o_mem_we    (mem_we),
        .o_mem_re    (mem_re),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .i_mem_rdata (mem_rdata)
    );

    tle_line_ram #(
        .DEPTH (LINE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

endmodule

/* design/tle_line_ram.sv */
// ----------------------------------------------------------------------------
// tle_line_ram
// Single-port line buffer, registered read data, valid the cycle after a read.
// ----------------------------------------------------------------------------
module tle_line_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/tle_seq.sv */
// ----------------------------------------------------------------------------
// tle_seq
// Key decode, escape tracking and erase sequencer around the line buffer.
// ----------------------------------------------------------------------------
module tle_seq
    import tle_pkg::*;
#(
    parameter int LINE_DEPTH = 256,
    parameter int AW         = $clog2(LINE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    tle_key_if.sink       i_key,
    tle_result_if.source  o_result,
    output logic          o_mem_we,
    output logic          o_mem_re,
    output logic [AW-1:0] o_mem_addr,
    output logic [7:0]    o_mem_wdata,
    input  logic [7:0]    i_mem_rdata
);

    localparam int LIM_CAP = (LINE_DEPTH > 255) ? 255 : LINE_DEPTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_DAT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_SEEN,
        ESC_CSI
    } t_esc;

    typedef enum logic [1:0] {
        ERASE_ONE,
        ERASE_WORD,
        ERASE_LINE
    } t_erase;

    t_state     r_state;
    t_esc       r_esc;
    t_erase     r_mode;
    logic       r_first;
    logic [7:0] r_cursor;
    logic [8:0] r_erase;
    t_result    r_res;
    t_result    r_out;
    logic       r_ov;

    logic [7:0] lim;
    logic [7:0] ch;
    logic       accept;
    logic       swallowed;
    t_esc       esc_n;
    t_result    dec_res;
    logic [7:0] dec_cursor;
    logic       dec_we;
    logic [7:0] dec_wdata;
    logic       dec_erase;
    t_erase     dec_mode;

    logic       keep;
    logic       stop;
    logic [8:0] n_erase;
    logic [7:0] n_cursor;

    assign lim    = (i_cfg.max_len > 8'(LIM_CAP)) ? 8'(LIM_CAP) : i_cfg.max_len;
    assign ch     = i_key.key_code;
    assign accept = i_key.valid && i_key.ready;

    assign i_key.ready = (r_state == S_IDLE);

    // decode of one key against the current line state
    always_comb begin
        esc_n      = r_esc;
        swallowed  = 1'b0;
        dec_res    = '0;
        dec_cursor = r_cursor;
        dec_we     = 1'b0;
        dec_wdata  = ch;
        dec_erase  = 1'b0;
        dec_mode   = ERASE_ONE;

        if (r_esc != ESC_NONE) begin
            if (r_esc == ESC_SEEN && ch != KEY_LBRACKET) begin
                esc_n = ESC_NONE;
            end else begin
                swallowed = 1'b1;
                if (r_esc == ESC_SEEN) begin
                    esc_n = ESC_CSI;
                end else if ((ch < KEY_DIGIT_0 || ch > KEY_DIGIT_9) && ch != KEY_SEMI) begin
                    esc_n = ESC_NONE;
                end else begin
                    esc_n = ESC_CSI;
                end
            end
        end

        if (!swallowed) begin
            if (ch > CTRL_MAX) begin
                if (r_cursor < lim) begin
                    if (!i_cfg.mixed_case && ch >= KEY_LOWER_A && ch <= KEY_LOWER_Z) begin
                        dec_wdata = ch - CASE_OFFSET;
                    end
                    dec_we              = 1'b1;
                    dec_res.store_valid = 1'b1;
                    dec_res.store_pos   = r_cursor;
                    dec_res.store_char  = dec_wdata;
                    dec_res.echo_kind   = ECHO_CHAR;
                    dec_res.echo_char   = dec_wdata;
                    dec_cursor          = r_cursor + 8'd1;
                end
                if (!i_cfg.enter_required && dec_cursor == lim) begin
                    dec_res.finished = 1'b1;
                end
            end else begin
                unique case (ch)
                    KEY_CR, KEY_SO: begin
                        dec_res.finished = 1'b1;
                    end
                    KEY_ETB: begin
                        dec_erase = (r_cursor != 8'd0);
                        dec_mode  = ERASE_WORD;
                    end
                    KEY_SUB: begin
                        if (i_cfg.ctrl_z_allowed && r_cursor < lim) begin
                            dec_we              = 1'b1;
                            dec_wdata           = KEY_SUB;
                            dec_res.store_valid = 1'b1;
                            dec_res.store_pos   = r_cursor;
                            dec_res.store_char  = KEY_SUB;
                            dec_res.echo_kind   = ECHO_CARET_Z;
                            dec_cursor          = r_cursor + 8'd1;
                        end
                    end
                    KEY_BS: begin
                        if (r_cursor != 8'd0) begin
                            dec_erase = 1'b1;
                        end else if (!i_cfg.enter_required) begin
                            dec_res.cancelled = 1'b1;
                        end
                    end
                    KEY_NAK, KEY_CAN: begin
                        dec_erase = (r_cursor != 8'd0);
                        dec_mode  = ERASE_LINE;
                    end
                    KEY_ESC: begin
                        esc_n = ESC_SEEN;
                    end
                    default: begin
                    end
                endcase
            end
        end

        dec_res.line_length = dec_cursor;
    end

    // one erase step on the byte just below the cursor
    always_comb begin
        keep     = (r_mode == ERASE_WORD) && !r_first && (i_mem_rdata == KEY_SPACE);
        n_erase  = keep ? r_erase
                        : r_erase + ((i_mem_rdata == KEY_SUB) ? 9'd2 : 9'd1);
        n_cursor = keep ? r_cursor : r_cursor - 8'd1;
        stop     = keep || (r_mode == ERASE_ONE) || (n_cursor == 8'd0);
    end

    assign o_mem_we    = accept && dec_we;
    assign o_mem_re    = (r_state == S_RD);
    assign o_mem_wdata = dec_wdata;
    assign o_mem_addr  = (r_state == S_RD) ? AW'(r_cursor - 8'd1) : AW'(r_cursor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_esc    <= ESC_NONE;
            r_cursor <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_ov || o_result.ready)) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res <= dec_res;
                        if (dec_res.finished || dec_res.cancelled) begin
                            r_cursor <= '0;
                            r_esc    <= ESC_NONE;
                        end else begin
                            r_cursor <= dec_cursor;
                            r_esc    <= esc_n;
                        end
                        if (dec_erase) begin
                            r_mode  <= dec_mode;
                            r_first <= 1'b1;
                            r_erase <= '0;
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_DAT;
                end
                S_DAT: begin
                    r_cursor <= n_cursor;
                    r_erase  <= n_erase;
                    r_first  <= 1'b0;
                    if (stop) begin
                        r_res.erase_cells <= n_erase;
                        r_res.line_length <= n_cursor;
                        r_state           <= S_OUT;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_OUT: begin
                    if (!r_ov || o_result.ready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_result.valid       = r_ov;
    assign o_result.echo_kind   = r_out.echo_kind;
    assign o_result.echo_char   = r_out.echo_char;
    assign o_result.erase_cells = r_out.erase_cells;
    assign o_result.store_valid = r_out.store_valid;
    assign o_result.store_pos   = r_out.store_pos;
    assign o_result.store_char  = r_out.store_char;
    assign o_result.finished    = r_out.finished;
    assign o_result.cancelled   = r_out.cancelled;
    assign o_result.line_length = r_out.line_length;

endmodule

/* design/tle_checker.sv */
// ----------------------------------------------------------------------------
// tle_checker
// Port-level checks on the line editor, bound to the top level.
// ----------------------------------------------------------------------------
module tle_checker
    import tle_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_echo_kind,
    input logic [8:0] i_erase_cells,
    input logic       i_store_valid,
    input logic [7:0] i_store_char,
    input logic       i_finished,
    input logic       i_cancelled
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    a_fin_canc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_finished && i_cancelled))
        else $error("line both finished and cancelled");

    a_store_no_erase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_store_valid |-> i_erase_cells == 9'd0 && !i_cancelled)
        else $error("store and erase in one transaction");

    a_caret_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_echo_kind == ECHO_CARET_Z |-> i_store_valid && i_store_char == KEY_SUB)
        else $error("caret-Z echo without marker store");

endmodule

bind terminal_line_editor_core tle_checker u_tle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_echo_kind   (o_result.echo_kind),
    .i_erase_cells (o_result.erase_cells),
    .i_store_valid (o_result.store_valid),
    .i_store_char  (o_result.store_char),
    .i_finished    (o_result.finished),
    .i_cancelled   (o_result.cancelled)
);

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the terminal line editor core.
// Keystrokes are driven through the key channel under random idling and
// back-pressure. Each result transaction is checked against a line-editing
// predictor that keeps its own cursor, escape state, line copy and settings.
// ----------------------------------------------------------------------------
module tb;
    import tle_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 5000000;
    localparam int unsigned REPORT_MAX  = 10;

    typedef enum logic [1:0] {ESC_IDLE, ESC_AFTER_ESC, ESC_IN_SEQ} t_esc_state;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;

    tle_key_if    key_ch ();
    tle_result_if res_ch ();

    terminal_line_editor_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (key_ch),
        .o_result    (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    logic [7:0]  line_copy [0:255];
    logic [7:0]  edit_cursor;
    t_esc_state  esc_state;
    t_cfg        cfg_copy;
    t_result     expected_results [$];
    logic [7:0]  pending_keys [$];
    int unsigned keys_added   = 0;
    logic        key_taken    = 1'b0;
    logic        rx_hold      = 1'b0;
    int unsigned tx_idle_pct  = 11;
    int unsigned rx_idle_pct  = 51;
    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count  = 0;
    t_result     seen_result;
    t_result     want_result;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [8:0] drop_last_char();
        edit_cursor = edit_cursor - 8'd1;
        return (line_copy[edit_cursor] == KEY_SUB) ? 9'd2 : 9'd1;
    endfunction

    function automatic t_result edit_line(input logic [7:0] key);
        t_result    r;
        logic [7:0] ch;
        logic [7:0] lim;
        logic       swallowed;
        r         = '0;
        ch        = key;
        lim       = cfg_copy.max_len;
        swallowed = 1'b0;

        if (esc_state == ESC_AFTER_ESC && ch != KEY_LBRACKET) begin
            esc_state = ESC_IDLE;
        end else if (esc_state != ESC_IDLE) begin
            swallowed = 1'b1;
            if (esc_state == ESC_IN_SEQ && (ch < KEY_DIGIT_0 || ch > KEY_DIGIT_9)
                    && ch != KEY_SEMI) begin
                esc_state = ESC_IDLE;
            end else begin
                esc_state = ESC_IN_SEQ;
            end
        end

        if (!swallowed) begin
            if (ch > CTRL_MAX) begin
                if (edit_cursor < lim) begin
                    if (!cfg_copy.mixed_case && ch >= KEY_LOWER_A && ch <= KEY_LOWER_Z)
                        ch = ch - CASE_OFFSET;
                    line_copy[edit_cursor] = ch;
                    r.store_valid = 1'b1;
                    r.store_pos   = edit_cursor;
                    r.store_char  = ch;
                    edit_cursor   = edit_cursor + 8'd1;
                    r.echo_kind   = ECHO_CHAR;
                    r.echo_char   = ch;
                end
                if (!cfg_copy.enter_required && edit_cursor == lim)
                    r.finished = 1'b1;
            end else begin
                case (ch)
                    KEY_CR, KEY_SO: begin
                        r.finished = 1'b1;
                    end
                    KEY_ETB: begin
                        if (edit_cursor != 0) begin
                            r.erase_cells = drop_last_char();
                            while (edit_cursor != 0 && line_copy[edit_cursor - 8'd1] != KEY_SPACE)
                                r.erase_cells = r.erase_cells + drop_last_char();
                        end
                    end
                    KEY_SUB: begin
                        if (cfg_copy.ctrl_z_allowed && edit_cursor < lim) begin
                            line_copy[edit_cursor] = KEY_SUB;
                            r.store_valid = 1'b1;
                            r.store_pos   = edit_cursor;
                            r.store_char  = KEY_SUB;
                            edit_cursor   = edit_cursor + 8'd1;
                            r.echo_kind   = ECHO_CARET_Z;
                        end
                    end
                    KEY_BS: begin
                        if (edit_cursor != 0)
                            r.erase_cells = drop_last_char();
                        else if (!cfg_copy.enter_required)
                            r.cancelled = 1'b1;
                    end
                    KEY_NAK, KEY_CAN: begin
                        while (edit_cursor != 0)
                            r.erase_cells = r.erase_cells + drop_last_char();
                    end
                    KEY_ESC: begin
                        esc_state = ESC_AFTER_ESC;
                    end
                    default: begin
                    end
                endcase
            end
        end

        r.line_length = edit_cursor;
        if (r.finished || r.cancelled) begin
            edit_cursor = '0;
            esc_state   = ESC_IDLE;
        end
        return r;
    endfunction

    function automatic string show_result(input t_result r);
        return $sformatf("kind=%0d char=%02h erase=%0d store=%0b@%0d:%02h fin=%0b canc=%0b len=%0d",
                         r.echo_kind, r.echo_char, r.erase_cells, r.store_valid, r.store_pos,
                         r.store_char, r.finished, r.cancelled, r.line_length);
    endfunction

    // ------------------------------------------------------------------
    // monitor: register writes, accepted keys and result transactions
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_taken               <= 1'b0;
            edit_cursor             = '0;
            esc_state               = ESC_IDLE;
            cfg_copy.max_len        = MAX_LEN_RESET;
            cfg_copy.mixed_case     = 1'b0;
            cfg_copy.enter_required = 1'b1;
            cfg_copy.ctrl_z_allowed = 1'b0;
        end else begin
            key_taken <= key_ch.valid && key_ch.ready;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_LEN:        cfg_copy.max_len        = i_cfg_data;
                    CFG_MIXED_CASE:     cfg_copy.mixed_case     = i_cfg_data[0];
                    CFG_ENTER_REQUIRED: cfg_copy.enter_required = i_cfg_data[0];
                    CFG_CTRL_Z_ALLOWED: cfg_copy.ctrl_z_allowed = i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (key_ch.valid && key_ch.ready)
                expected_results.push_back(edit_line(key_ch.key_code));
            if (res_ch.valid && res_ch.ready) begin
                seen_result.echo_kind   = res_ch.echo_kind;
                seen_result.echo_char   = res_ch.echo_char;
                seen_result.erase_cells = res_ch.erase_cells;
                seen_result.store_valid = res_ch.store_valid;
                seen_result.store_pos   = res_ch.store_pos;
                seen_result.store_char  = res_ch.store_char;
                seen_result.finished    = res_ch.finished;
                seen_result.cancelled   = res_ch.cancelled;
                seen_result.line_length = res_ch.line_length;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("result %0d: unexpected transaction %s",
                                 results_seen, show_result(seen_result));
                end else begin
                    want_result = expected_results.pop_front();
                    if (seen_result !== want_result) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("result %0d: expected %s, got %s", results_seen,
                                     show_result(want_result), show_result(seen_result));
                    end
                end
                results_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // key driver and result receiver
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            key_ch.valid <= 1'b0;
        end else if (!key_ch.valid || key_taken) begin
            if (pending_keys.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                key_ch.valid    <= 1'b1;
                key_ch.key_code <= pending_keys.pop_front();
            end else begin
                key_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[terminal_line_editor_core] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic void add_key(input logic [7:0] k);
        pending_keys.push_back(k);
        keys_added++;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [7:0] max_len, input logic mixed,
                            input logic enter, input logic ctrl_z);
        write_reg(CFG_MAX_LEN, max_len);
        write_reg(CFG_MIXED_CASE, {7'd0, mixed});
        write_reg(CFG_ENTER_REQUIRED, {7'd0, enter});
        write_reg(CFG_CTRL_Z_ALLOWED, {7'd0, ctrl_z});
    endtask

    // all keys accepted and every result transaction back
    task automatic drain();
        @(posedge i_clk);
        while (pending_keys.size() != 0 || key_ch.valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic hold_receiver(input int unsigned cycles);
        rx_hold = 1'b1;
        repeat (cycles) @(posedge i_clk);
        rx_hold = 1'b0;
    endtask

    // lines of random content, mostly well formed, with edits, escapes and noise
    task automatic queue_lines(input int unsigned n_items, input int unsigned long_pct);
        int unsigned target;
        int unsigned line_len;
        int unsigned pick;
        int unsigned k;
        target = keys_added + n_items;
        while (keys_added < target) begin
            if ($urandom_range(0, 99) < long_pct)
                line_len = $urandom_range(200, 300);
            else
                line_len = $urandom_range(0, 20);
            for (k = 0; k < line_len; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    add_key(8'($urandom_range(32, 255)));
                end else if (pick < 62) begin
                    add_key(8'($urandom_range(KEY_LOWER_A, KEY_LOWER_Z)));
                end else if (pick < 66) begin
                    add_key(KEY_SPACE);
                end else if (pick < 71) begin
                    add_key(KEY_SUB);
                end else if (pick < 76) begin
                    add_key(KEY_BS);
                end else if (pick < 78) begin
                    add_key(KEY_ETB);
                end else if (pick < 79) begin
                    add_key($urandom_range(0, 1) ? KEY_NAK : KEY_CAN);
                end else if (pick < 87) begin
                    add_key(KEY_ESC);
                    if ($urandom_range(0, 9) < 8) begin
                        add_key(KEY_LBRACKET);
                        repeat ($urandom_range(0, 3))
                            add_key(($urandom_range(0, 10) == 10) ? KEY_SEMI
                                    : KEY_DIGIT_0 + 8'($urandom_range(0, 9)));
                        add_key(8'($urandom_range(64, 126)));
                    end
                end else begin
                    add_key(8'($urandom_range(0, 255)));
                end
            end
            pick = $urandom_range(0, 9);
            if (pick < 4)
                add_key(KEY_CR);
            else if (pick < 8)
                add_key(KEY_SO);
            else if (pick < 9)
                add_key(KEY_CAN);
        end
    endtask

    initial begin
        key_ch.valid    = 1'b0;
        key_ch.key_code = '0;
        res_ch.ready    = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_MAX_LEN;
        i_cfg_data      = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: case folding, controls, escapes, erases, both enters
        add_key("a");
        add_key(KEY_SPACE);
        add_key(8'hFF);
        add_key(8'h00);
        add_key(CTRL_MAX);
        add_key(KEY_SUB);
        add_key(KEY_ESC);
        add_key(KEY_LBRACKET);
        add_key(KEY_DIGIT_9);
        add_key(KEY_SEMI);
        add_key("m");
        add_key(KEY_ESC);
        add_key("q");
        add_key(KEY_ETB);
        add_key(KEY_BS);
        add_key(KEY_NAK);
        add_key(KEY_BS);
        add_key("z");
        add_key(KEY_CAN);
        add_key(KEY_CR);
        add_key(KEY_SO);
        drain();

        // auto-submit: cancel on empty line, no finish on a marker at the limit
        set_mode(8'd2, 1'b1, 1'b0, 1'b1);
        add_key(KEY_BS);
        add_key("a");
        add_key(KEY_SUB);
        drain();
        write_reg(CFG_MAX_LEN, 8'd0);
        add_key("b");
        drain();

        // limit lowered mid-line, cursor left beyond it
        write_reg(CFG_MAX_LEN, 8'd255);
        add_key("a");
        add_key("b");
        add_key("c");
        drain();
        write_reg(CFG_MAX_LEN, 8'd1);
        add_key("d");
        add_key(KEY_SUB);
        add_key(KEY_BS);
        add_key(KEY_ETB);
        drain();

        set_mode(8'd80, 1'b0, 1'b1, 1'b0);
        queue_lines(250, 5);
        drain();

        // long receiver stall while keys keep coming
        set_mode(8'd255, 1'b1, 1'b1, 1'b1);
        fork
            hold_receiver(800);
        join_none
        queue_lines(350, 15);
        drain();

        tx_idle_pct = 51;
        rx_idle_pct = 11;
        set_mode(8'd1, 1'b0, 1'b0, 1'b1);
        queue_lines(150, 0);
        drain();

        set_mode(8'd17, 1'b1, 1'b0, 1'b0);
        queue_lines(120, 5);
        drain();
        queue_lines(130, 5);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (2) begin
            set_mode(8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            queue_lines(175, 5);
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("[terminal_line_editor_core] OK");
        else
            $display("[terminal_line_editor_core] ERROR");
        $finish;
    end

endmodule
